/* design/sha224_pkg.sv */
// Shared types, constants and round functions of the SHA-224 stream hasher.
// Used by the controller, the datapath and the top level. No dependencies.
package sha224_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 61;
    localparam int LEN_W    = 64;
    localparam int USED_W   = 6;
    localparam int ROUND_W  = 6;
    localparam int IDX_W    = 3;
    localparam int NUM_HASH = 8;
    localparam int NUM_SCHED = 16;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [BYTE_W-1:0]  PAD_MARK       = 8'h80;
    localparam logic [USED_W-1:0]  USED_LAST      = 6'h3F;
    localparam logic [USED_W-1:0]  USED_LEN_START = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST     = 6'd63;
    localparam logic [IDX_W-1:0]   LAST_WORD_IDX  = 3'd6;

    localparam logic [WORD_W-1:0] INIT_HASH [0:NUM_HASH-1] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam logic [WORD_W-1:0] ROUND_K [0:63] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMP_INIT,
        ST_COMP_ROUND,
        ST_COMP_ADD,
        ST_OUTPUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic                wr_byte;
        t_byte_sel           byte_sel;
        logic                latch_len;
        logic                comp_init;
        logic                comp_round;
        logic [ROUND_W-1:0]  round;
        logic                comp_add;
        logic                out_shift;
        logic                restart;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [USED_W-1:0] used;
    } t_dp_status;

    function automatic logic [WORD_W-1:0] f_big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] f_big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] f_small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] f_small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* design/sha224_stream_if.sv */
// Valid/ready channel interfaces for the SHA-224 stream hasher.
// Depends on sha224_pkg for the field widths.
interface sha224_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [sha224_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha224_out_if;
    logic                            valid;
    logic                            ready;
    logic [sha224_pkg::WORD_W-1:0]   digest_word;
    logic [sha224_pkg::IDX_W-1:0]    word_index;
    logic                            last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

/* design/sha224_ctrl.sv */
// Sequencing state machine of the SHA-224 stream hasher: absorb, padding,
// compression rounds and digest output. Depends on sha224_pkg.
module sha224_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_op,
    output logic                            o_in_ready,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [sha224_pkg::IDX_W-1:0]    o_word_index,
    output logic                            o_last_word,
    output sha224_pkg::t_ctrl_cmd           o_cmd,
    input  sha224_pkg::t_dp_status          i_status
);

    sha224_pkg::t_state                  r_state, n_state;
    sha224_pkg::t_state                  r_ret, n_ret;
    logic [sha224_pkg::ROUND_W-1:0]      r_round, n_round;
    logic [sha224_pkg::IDX_W-1:0]        r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha224_pkg::ST_IDLE;
            r_ret   <= sha224_pkg::ST_IDLE;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.byte_sel = sha224_pkg::SEL_DATA;
        o_cmd.round = r_round;

        unique case (r_state)
            sha224_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == sha224_pkg::OP_FINISH) begin
                        o_cmd.latch_len = 1'b1;
                        n_state = sha224_pkg::ST_PAD_MARK;
                    end else begin
                        o_cmd.wr_byte = 1'b1;
                        if (i_status.used == sha224_pkg::USED_LAST) begin
                            n_ret   = sha224_pkg::ST_IDLE;
                            n_state = sha224_pkg::ST_COMP_INIT;
                        end
                    end
                end
            end
            sha224_pkg::ST_PAD_MARK: begin
                o_cmd.wr_byte  = 1'b1;
                o_cmd.byte_sel = sha224_pkg::SEL_MARK;
                n_ret   = sha224_pkg::ST_PAD_ZERO;
                n_state = (i_status.used == sha224_pkg::USED_LAST) ?
                          sha224_pkg::ST_COMP_INIT : sha224_pkg::ST_PAD_ZERO;
            end
            sha224_pkg::ST_PAD_ZERO: begin
                if (i_status.used == sha224_pkg::USED_LEN_START) begin
                    n_state = sha224_pkg::ST_PAD_LEN;
                end else begin
                    o_cmd.wr_byte  = 1'b1;
                    o_cmd.byte_sel = sha224_pkg::SEL_ZERO;
                    if (i_status.used == sha224_pkg::USED_LAST) begin
                        n_ret   = sha224_pkg::ST_PAD_ZERO;
                        n_state = sha224_pkg::ST_COMP_INIT;
                    end
                end
            end
            sha224_pkg::ST_PAD_LEN: begin
                o_cmd.wr_byte  = 1'b1;
                o_cmd.byte_sel = sha224_pkg::SEL_LEN;
                if (i_status.used == sha224_pkg::USED_LAST) begin
                    n_ret   = sha224_pkg::ST_OUTPUT;
                    n_state = sha224_pkg::ST_COMP_INIT;
                end
            end
            sha224_pkg::ST_COMP_INIT: begin
                o_cmd.comp_init = 1'b1;
                n_round = '0;
                n_state = sha224_pkg::ST_COMP_ROUND;
            end
            sha224_pkg::ST_COMP_ROUND: begin
                o_cmd.comp_round = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == sha224_pkg::ROUND_LAST) begin
                    n_state = sha224_pkg::ST_COMP_ADD;
                end
            end
            sha224_pkg::ST_COMP_ADD: begin
                o_cmd.comp_add = 1'b1;
                n_state = r_ret;
            end
            sha224_pkg::ST_OUTPUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == sha224_pkg::LAST_WORD_IDX) begin
                        o_cmd.restart = 1'b1;
                        n_idx   = '0;
                        n_state = sha224_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha224_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == sha224_pkg::LAST_WORD_IDX);

endmodule

/* design/sha224_datapath.sv */
// Datapath of the SHA-224 stream hasher: byte packing, message schedule
// shift line, round logic, hash words and byte count. Depends on sha224_pkg.
module sha224_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sha224_pkg::BYTE_W-1:0]    i_data_byte,
    input  sha224_pkg::t_ctrl_cmd            i_cmd,
    output sha224_pkg::t_dp_status           o_status,
    output logic [sha224_pkg::WORD_W-1:0]    o_digest_word
);

    localparam int NH = sha224_pkg::NUM_HASH;
    localparam int NS = sha224_pkg::NUM_SCHED;

    logic [sha224_pkg::WORD_W-1:0]   r_hash [NH];
    logic [sha224_pkg::WORD_W-1:0]   n_hash [NH];
    logic [sha224_pkg::WORD_W-1:0]   r_var  [NH];
    logic [sha224_pkg::WORD_W-1:0]   n_var  [NH];
    logic [sha224_pkg::WORD_W-1:0]   r_sched [NS];
    logic [sha224_pkg::WORD_W-1:0]   n_sched [NS];
    logic [23:0]                     r_acc, n_acc;
    logic [sha224_pkg::LEN_W-1:0]    r_len, n_len;
    logic [sha224_pkg::COUNT_W-1:0]  r_count, n_count;

    logic [sha224_pkg::BYTE_W-1:0]   w_byte;
    logic [sha224_pkg::WORD_W-1:0]   w_word;
    logic [sha224_pkg::WORD_W-1:0]   w_next_sched;
    logic [sha224_pkg::WORD_W-1:0]   w_t1, w_t2;

    always_comb begin
        unique case (i_cmd.byte_sel)
            sha224_pkg::SEL_DATA: w_byte = i_data_byte;
            sha224_pkg::SEL_MARK: w_byte = sha224_pkg::PAD_MARK;
            sha224_pkg::SEL_ZERO: w_byte = '0;
            sha224_pkg::SEL_LEN:  w_byte = r_len[sha224_pkg::LEN_W-1 -: sha224_pkg::BYTE_W];
            default:              w_byte = '0;
        endcase
    end

    assign w_word = {r_acc, w_byte};

    assign w_next_sched = sha224_pkg::f_small_sigma1(r_sched[14]) + r_sched[9] +
                          sha224_pkg::f_small_sigma0(r_sched[1]) + r_sched[0];

    assign w_t1 = r_var[7] + sha224_pkg::f_big_sigma1(r_var[4]) +
                  ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6])) +
                  sha224_pkg::ROUND_K[i_cmd.round] + r_sched[0];
    assign w_t2 = sha224_pkg::f_big_sigma0(r_var[0]) +
                  ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));

    always_comb begin
        n_acc   = r_acc;
        n_len   = r_len;
        n_count = r_count;
        n_sched = r_sched;
        n_var   = r_var;
        n_hash  = r_hash;

        if (i_cmd.latch_len) begin
            n_len = {r_count, 3'b000};
        end

        if (i_cmd.wr_byte) begin
            n_acc   = w_word[23:0];
            n_count = r_count + 1'b1;
            if (i_cmd.byte_sel == sha224_pkg::SEL_LEN) begin
                n_len = {r_len[sha224_pkg::LEN_W-sha224_pkg::BYTE_W-1:0],
                         {sha224_pkg::BYTE_W{1'b0}}};
            end
            if (r_count[1:0] == 2'b11) begin
                for (int i = 0; i < NS - 1; i++) begin
                    n_sched[i] = r_sched[i+1];
                end
                n_sched[NS-1] = w_word;
            end
        end

        if (i_cmd.comp_init) begin
            n_var = r_hash;
        end

        if (i_cmd.comp_round) begin
            for (int i = 0; i < NS - 1; i++) begin
                n_sched[i] = r_sched[i+1];
            end
            n_sched[NS-1] = w_next_sched;
            for (int i = 1; i < NH; i++) begin
                n_var[i] = r_var[i-1];
            end
            n_var[4] = r_var[3] + w_t1;
            n_var[0] = w_t1 + w_t2;
        end

        if (i_cmd.comp_add) begin
            for (int i = 0; i < NH; i++) begin
                n_hash[i] = r_hash[i] + r_var[i];
            end
        end

        if (i_cmd.out_shift) begin
            for (int i = 0; i < NH - 1; i++) begin
                n_hash[i] = r_hash[i+1];
            end
        end

        if (i_cmd.restart) begin
            n_hash  = sha224_pkg::INIT_HASH;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= sha224_pkg::INIT_HASH;
            r_count <= '0;
        end else begin
            r_hash  <= n_hash;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_len   <= n_len;
        r_sched <= n_sched;
        r_var   <= n_var;
    end

    assign o_status.used = r_count[sha224_pkg::USED_W-1:0];
    assign o_digest_word = r_hash[0];

endmodule

/* design/sha224_stream_hasher_top.sv */
// Top level of the SHA-224 stream hasher: joins the controller and the
// datapath to the input and output channels. Depends on sha224_pkg,
// sha224_stream_if, sha224_ctrl and sha224_datapath.
//
// The input channel carries one beat per item: op 0 absorbs data_byte, op 1
// finishes the message. The beat that fills a 64-byte block is followed by
// the compression (a load step, 64 rounds through a single round unit, an
// add step), during which the block takes no new byte.
// A finish beat pads the block a byte at a time, compresses once or twice
// and then offers seven output beats of 32-bit digest words, word_index 0
// to 6, with last_word set on the seventh. The block takes no input beat
// while it pads, compresses or shows the digest; a stalled receiver simply
// holds the current word, and the block waits. After the seventh word it
// returns to the initial hash with a zero count. Synchronous reset clears
// the count, loads the initial hash and leaves the block ready for input.
module sha224_stream_hasher_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha224_in_if.sink            i_in,
    sha224_out_if.source         o_out
);

    sha224_pkg::t_ctrl_cmd       w_cmd;
    sha224_pkg::t_dp_status      w_status;
    logic                        w_in_ready;
    logic                        w_out_valid;
    logic [sha224_pkg::IDX_W-1:0]  w_word_index;
    logic                        w_last_word;
    logic [sha224_pkg::WORD_W-1:0] w_digest_word;

    sha224_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_op      (i_in.op),
        .o_in_ready   (w_in_ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (w_out_valid),
        .o_word_index (w_word_index),
        .o_last_word  (w_last_word),
        .o_cmd        (w_cmd),
        .i_status     (w_status)
    );

    sha224_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_digest_word (w_digest_word)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.digest_word = w_digest_word;
    assign o_out.word_index  = w_word_index;
    assign o_out.last_word   = w_last_word;

endmodule
